// File: hw/rtl/ttw_pkg.sv
package ttw_pkg;

   // screen geometry defaults
   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // fixed field widths
   localparam int CMD_W     = 2;
   localparam int CHAR_W    = 8;
   localparam int CELL_W    = 16;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;
   localparam int COLOR_W   = 8;

   localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;
   localparam logic [CELL_W-1:0]  CELL_RESET  = 16'h0720;

   // tab stops
   localparam int TAB_STEP = 4;
   localparam int TAB_BITS = $clog2(TAB_STEP);
   localparam int TAB_W    = TAB_BITS + 1;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0a;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0d;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // kind of work a transfer asks for
   typedef logic [2:0] kind_type;
   localparam kind_type K_PLAIN   = 3'd0;
   localparam kind_type K_NEWLINE = 3'd1;
   localparam kind_type K_RETURN  = 3'd2;
   localparam kind_type K_TAB     = 3'd3;
   localparam kind_type K_BACK    = 3'd4;
   localparam kind_type K_CLEAR   = 3'd5;
   localparam kind_type K_READ    = 3'd6;
   localparam kind_type K_NOP     = 3'd7;

   // screen store address source
   typedef logic [2:0] addr_sel_type;
   localparam addr_sel_type ADDR_SWEEP    = 3'd0;
   localparam addr_sel_type ADDR_CURSOR   = 3'd1;
   localparam addr_sel_type ADDR_BACK     = 3'd2;
   localparam addr_sel_type ADDR_LAST_ROW = 3'd3;
   localparam addr_sel_type ADDR_REQ      = 3'd4;

   // screen store write data
   typedef logic [1:0] wdata_sel_type;
   localparam wdata_sel_type WD_INIT  = 2'd0;
   localparam wdata_sel_type WD_BLANK = 2'd1;
   localparam wdata_sel_type WD_CHAR  = 2'd2;

   // cursor update
   typedef logic [2:0] cur_op_type;
   localparam cur_op_type CUR_HOLD    = 3'd0;
   localparam cur_op_type CUR_ADVANCE = 3'd1;
   localparam cur_op_type CUR_NEWLINE = 3'd2;
   localparam cur_op_type CUR_RETURN  = 3'd3;
   localparam cur_op_type CUR_BACK    = 3'd4;
   localparam cur_op_type CUR_SCROLL  = 3'd5;
   localparam cur_op_type CUR_HOME    = 3'd6;

   typedef struct packed {
      logic          latch_req;
      logic          ram_we;
      addr_sel_type  addr_sel;
      wdata_sel_type wdata_sel;
      cur_op_type    cur_op;
      logic          sweep_clr;
      logic          sweep_inc;
      logic          tab_dec;
      logic          cell_cap;
      logic          rsp_load;
   } ctl_type;

   typedef struct packed {
      kind_type req_kind;
      kind_type kind;
      logic     col_last;
      logic     row_last;
      logic     at_home;
      logic     tab_more;
      logic     tab_pending;
      logic     sweep_end_cells;
      logic     sweep_end_cols;
   } st_type;

   function automatic kind_type kind_of(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch);
      kind_type k;
      k = K_NOP;
      if (cmd == CMD_PUT) begin
         if (ch == CHAR_NEWLINE) k = K_NEWLINE;
         else if (ch == CHAR_RETURN) k = K_RETURN;
         else if (ch == CHAR_TAB) k = K_TAB;
         else if (ch == CHAR_BACKSPACE) k = K_BACK;
         else k = K_PLAIN;
      end else if (cmd == CMD_CLEAR) begin
         k = K_CLEAR;
      end else if (cmd == CMD_READ) begin
         k = K_READ;
      end
      return k;
   endfunction

endpackage

// File: hw/rtl/ttw_ram.sv
module ttw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[addr] <= wdata;
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/ttw_ctrl.sv
module ttw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  ttw_pkg::st_type  st,
   output ttw_pkg::ctl_type ctl
);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_PUT    = 3'd2;
   localparam logic [2:0] S_MOVE   = 3'd3;
   localparam logic [2:0] S_SCROLL = 3'd4;
   localparam logic [2:0] S_CLEAR  = 3'd5;
   localparam logic [2:0] S_READ   = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       req_accept;

   function automatic logic [2:0] start_state(ttw_pkg::kind_type k);
      logic [2:0] s;
      case (k) inside
         ttw_pkg::K_PLAIN, ttw_pkg::K_TAB:                   s = S_PUT;
         ttw_pkg::K_NEWLINE, ttw_pkg::K_RETURN, ttw_pkg::K_BACK: s = S_MOVE;
         ttw_pkg::K_CLEAR:                                   s = S_CLEAR;
         ttw_pkg::K_READ:                                    s = S_READ;
         default:                                            s = S_DONE;
      endcase
      return s;
   endfunction

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == S_IDLE) || ((state_ff == S_DONE) && out_free));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      ctl           = '0;
      ctl.addr_sel  = ttw_pkg::ADDR_REQ;
      ctl.wdata_sel = ttw_pkg::WD_BLANK;
      ctl.cur_op    = ttw_pkg::CUR_HOLD;
      state_in      = state_ff;
      unique case (state_ff)
         S_INIT: begin
            ctl.ram_we    = 1'b1;
            ctl.addr_sel  = ttw_pkg::ADDR_SWEEP;
            ctl.wdata_sel = ttw_pkg::WD_INIT;
            ctl.sweep_inc = 1'b1;
            if (st.sweep_end_cells) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               ctl.latch_req = 1'b1;
               state_in      = start_state(st.req_kind);
            end
         end
         S_PUT: begin
            ctl.ram_we    = 1'b1;
            ctl.addr_sel  = ttw_pkg::ADDR_CURSOR;
            ctl.wdata_sel = ttw_pkg::WD_CHAR;
            ctl.tab_dec   = 1'b1;
            if (st.col_last && st.row_last) begin
               ctl.cur_op    = ttw_pkg::CUR_SCROLL;
               ctl.sweep_clr = 1'b1;
               state_in      = S_SCROLL;
            end else begin
               ctl.cur_op = ttw_pkg::CUR_ADVANCE;
               state_in   = st.tab_more ? S_PUT : S_DONE;
            end
         end
         S_MOVE: begin
            state_in = S_DONE;
            case (st.kind)
               ttw_pkg::K_NEWLINE: begin
                  if (st.row_last) begin
                     ctl.cur_op    = ttw_pkg::CUR_SCROLL;
                     ctl.sweep_clr = 1'b1;
                     state_in      = S_SCROLL;
                  end else begin
                     ctl.cur_op = ttw_pkg::CUR_NEWLINE;
                  end
               end
               ttw_pkg::K_RETURN: ctl.cur_op = ttw_pkg::CUR_RETURN;
               ttw_pkg::K_BACK: begin
                  // nothing to blank at home
                  ctl.ram_we   = !st.at_home;
                  ctl.addr_sel = ttw_pkg::ADDR_BACK;
                  ctl.cur_op   = ttw_pkg::CUR_BACK;
               end
               default: ctl.cur_op = ttw_pkg::CUR_HOLD;
            endcase
         end
         S_SCROLL: begin
            ctl.ram_we    = 1'b1;
            ctl.addr_sel  = ttw_pkg::ADDR_LAST_ROW;
            ctl.sweep_inc = 1'b1;
            // a tab may still have blanks to put after the scroll
            if (st.sweep_end_cols) state_in = st.tab_pending ? S_PUT : S_DONE;
         end
         S_CLEAR: begin
            ctl.ram_we    = 1'b1;
            ctl.addr_sel  = ttw_pkg::ADDR_SWEEP;
            ctl.sweep_inc = 1'b1;
            if (st.sweep_end_cells) begin
               ctl.cur_op = ttw_pkg::CUR_HOME;
               state_in   = S_DONE;
            end
         end
         S_READ: begin
            ctl.cell_cap = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               ctl.rsp_load = 1'b1;
               if (req_valid) begin
                  ctl.latch_req = 1'b1;
                  state_in      = start_state(st.req_kind);
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = ctl.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register loaded while still held");

   // the screen store is left alone while waiting for work
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !ctl.ram_we)
      else $error("screen store written outside a command");

   // a read transfer captures its cell on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && st.req_kind == ttw_pkg::K_READ) |=> (state_ff == S_READ))
      else $error("read command did not reach the capture step");

endmodule

// File: hw/rtl/ttw_datapath.sv
module ttw_datapath #(
   parameter int COLUMNS = ttw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = ttw_pkg::ROWS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ttw_pkg::CMD_W-1:0]       req_cmd,
   input  logic [ttw_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [ttw_pkg::ROW_OUT_W-1:0]   req_cell_row,
   input  logic [ttw_pkg::COL_OUT_W-1:0]   req_cell_col,
   input  logic [ttw_pkg::COLOR_W-1:0]     text_color,
   input  ttw_pkg::ctl_type                ctl,
   output ttw_pkg::st_type                 st,
   output logic                            ram_we,
   output logic [$clog2(ROWS*COLUMNS)-1:0] ram_addr,
   output logic [ttw_pkg::CELL_W-1:0]      ram_wdata,
   input  logic [ttw_pkg::CELL_W-1:0]      ram_rdata,
   output logic [ttw_pkg::ROW_OUT_W-1:0]   rsp_cursor_row,
   output logic [ttw_pkg::COL_OUT_W-1:0]   rsp_cursor_col,
   output logic [ttw_pkg::CELL_W-1:0]      rsp_cell_value,
   output logic                            rsp_scrolled
);

   localparam int CELLS     = ROWS * COLUMNS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int TAB_W     = ttw_pkg::TAB_W;
   localparam int TAB_BITS  = ttw_pkg::TAB_BITS;
   localparam int ROW_OUT_W = ttw_pkg::ROW_OUT_W;
   localparam int COL_OUT_W = ttw_pkg::COL_OUT_W;
   localparam int CELL_W    = ttw_pkg::CELL_W;
   localparam int CHAR_W    = ttw_pkg::CHAR_W;

   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [TAB_W-1:0]  tab_left_ff, tab_left_in;
   ttw_pkg::kind_type kind_ff;
   logic [CHAR_W-1:0] char_ff;
   logic              in_range_ff;
   logic              scrolled_ff, scrolled_in;
   logic [CELL_W-1:0] cell_ff;

   logic [ROW_OUT_W-1:0] rsp_row_ff;
   logic [COL_OUT_W-1:0] rsp_col_ff;
   logic [CELL_W-1:0]    rsp_cell_ff;
   logic                 rsp_scrolled_ff;

   ttw_pkg::kind_type req_kind;
   logic              req_in_range;
   logic [ROW_W-1:0]  req_row;
   logic [COL_W-1:0]  req_col;
   logic [ROW_W-1:0]  bk_row;
   logic [COL_W-1:0]  bk_col;
   logic [ROW_W-1:0]  a_row;
   logic [COL_W-1:0]  a_col;
   logic [ROW_W:0]    row_sum;
   logic [ROW_W-1:0]  p_row;
   logic [ADDR_W-1:0] cell_addr;

   assign req_kind     = ttw_pkg::kind_of(req_cmd, req_char_code);
   assign req_in_range = (32'(req_cell_row) < ROWS) && (32'(req_cell_col) < COLUMNS);
   assign req_row      = req_in_range ? ROW_W'(req_cell_row) : '0;
   assign req_col      = req_in_range ? COL_W'(req_cell_col) : '0;

   // backspace target: previous cell, or end of the previous row
   always_comb begin
      bk_row = row_ff;
      bk_col = col_ff;
      if (col_ff != '0) begin
         bk_col = col_ff - COL_W'(1);
      end else if (row_ff != '0) begin
         bk_row = row_ff - ROW_W'(1);
         bk_col = COL_LAST;
      end
   end

   // rows live in a ring: top_ff is the store row shown as row 0
   always_comb begin
      case (ctl.addr_sel)
         ttw_pkg::ADDR_CURSOR: begin
            a_row = row_ff;
            a_col = col_ff;
         end
         ttw_pkg::ADDR_BACK: begin
            a_row = bk_row;
            a_col = bk_col;
         end
         ttw_pkg::ADDR_LAST_ROW: begin
            a_row = ROW_LAST;
            a_col = COL_W'(sweep_ff);
         end
         default: begin
            a_row = req_row;
            a_col = req_col;
         end
      endcase
      row_sum   = (ROW_W+1)'(a_row) + (ROW_W+1)'(top_ff);
      p_row     = (row_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(row_sum - (ROW_W+1)'(ROWS))
                                                : ROW_W'(row_sum);
      cell_addr = ADDR_W'(ADDR_W'(p_row) * ADDR_W'(COLUMNS)) + ADDR_W'(a_col);
   end

   assign ram_we   = ctl.ram_we;
   assign ram_addr = (ctl.addr_sel == ttw_pkg::ADDR_SWEEP) ? sweep_ff : cell_addr;

   always_comb begin
      case (ctl.wdata_sel)
         ttw_pkg::WD_INIT: ram_wdata = ttw_pkg::CELL_RESET;
         ttw_pkg::WD_CHAR: ram_wdata = {text_color, char_ff};
         default:          ram_wdata = {text_color, ttw_pkg::CHAR_BLANK};
      endcase
   end

   // cursor and ring top
   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      top_in      = top_ff;
      scrolled_in = scrolled_ff;
      case (ctl.cur_op)
         ttw_pkg::CUR_ADVANCE: begin
            if (col_ff == COL_LAST) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ttw_pkg::CUR_NEWLINE: begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end
         ttw_pkg::CUR_RETURN: col_in = '0;
         ttw_pkg::CUR_BACK: begin
            row_in = bk_row;
            col_in = bk_col;
         end
         ttw_pkg::CUR_SCROLL: begin
            row_in      = ROW_LAST;
            col_in      = '0;
            top_in      = (top_ff == ROW_LAST) ? '0 : top_ff + ROW_W'(1);
            scrolled_in = 1'b1;
         end
         ttw_pkg::CUR_HOME: begin
            row_in = '0;
            col_in = '0;
            top_in = '0;
         end
         default: row_in = row_ff;
      endcase
      if (ctl.latch_req) scrolled_in = 1'b0;
   end

   always_comb begin
      sweep_in = sweep_ff;
      if (ctl.sweep_clr || ctl.latch_req) sweep_in = '0;
      else if (ctl.sweep_inc) sweep_in = sweep_ff + ADDR_W'(1);
   end

   always_comb begin
      tab_left_in = tab_left_ff;
      if (ctl.latch_req) begin
         case (req_kind)
            ttw_pkg::K_TAB:
               tab_left_in = TAB_W'(ttw_pkg::TAB_STEP) - TAB_W'(col_ff[TAB_BITS-1:0]);
            ttw_pkg::K_PLAIN: tab_left_in = TAB_W'(1);
            default:          tab_left_in = '0;
         endcase
      end else if (ctl.tab_dec) begin
         tab_left_in = tab_left_ff - TAB_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         top_ff      <= '0;
         sweep_ff    <= '0;
         scrolled_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         top_ff      <= top_in;
         sweep_ff    <= sweep_in;
         scrolled_ff <= scrolled_in;
      end
   end

   always_ff @(posedge clock) begin
      tab_left_ff <= tab_left_in;
      if (ctl.latch_req) begin
         kind_ff     <= req_kind;
         char_ff     <= (req_kind == ttw_pkg::K_TAB) ? ttw_pkg::CHAR_BLANK : req_char_code;
         in_range_ff <= req_in_range;
         cell_ff     <= '0;
      end else if (ctl.cell_cap) begin
         cell_ff <= in_range_ff ? ram_rdata : '0;
      end
      if (ctl.rsp_load) begin
         rsp_row_ff      <= ROW_OUT_W'(row_ff);
         rsp_col_ff      <= COL_OUT_W'(col_ff);
         rsp_cell_ff     <= cell_ff;
         rsp_scrolled_ff <= scrolled_ff;
      end
   end

   assign st.req_kind        = req_kind;
   assign st.kind            = kind_ff;
   assign st.col_last        = (col_ff == COL_LAST);
   assign st.row_last        = (row_ff == ROW_LAST);
   assign st.at_home         = (row_ff == '0) && (col_ff == '0);
   assign st.tab_more        = (tab_left_ff > TAB_W'(1));
   assign st.tab_pending     = (tab_left_ff != '0);
   assign st.sweep_end_cells = (sweep_ff == ADDR_W'(CELLS - 1));
   assign st.sweep_end_cols  = (sweep_ff == ADDR_W'(COLUMNS - 1));

   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

   // cursor stays on the screen between steps
   assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < ROWS) && (32'(col_ff) < COLUMNS))
      else $error("cursor left the screen");

   // ring top always names a real store row
   assert property (@(posedge clock) disable iff (reset)
      32'(top_ff) < ROWS)
      else $error("ring top out of range");

endmodule

// File: hw/rtl/text_terminal_writer_core.sv
// channel   direction  handshake                     payload
// req_      in         req_valid / req_stall         cmd, char_code, cell_row, cell_col
// rsp_      out        rsp_valid / rsp_stall         cursor_row, cursor_col, cell_value, scrolled
// csr_      in         psel, penable, pwrite, pready text_color at address 0
//
// tab: puts 1 to 4 blanks, up to the next tab stop
// a character or tab blank put in the last cell, or a newline on the last row, scrolls and blanks the last row
// clear screen: blanks every cell, one per cycle through the single screen store write port
// reset: a pass over every cell fills the screen store before req_ is taken
// a held result does not block the next transfer until it is done
module text_terminal_writer_core #(
   parameter int COLUMNS = ttw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = ttw_pkg::ROWS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ttw_pkg::CMD_W-1:0]     req_cmd,
   input  logic [ttw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [ttw_pkg::ROW_OUT_W-1:0] req_cell_row,
   input  logic [ttw_pkg::COL_OUT_W-1:0] req_cell_col,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ttw_pkg::ROW_OUT_W-1:0] rsp_cursor_row,
   output logic [ttw_pkg::COL_OUT_W-1:0] rsp_cursor_col,
   output logic [ttw_pkg::CELL_W-1:0]    rsp_cell_value,
   output logic                          rsp_scrolled,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   localparam int CELLS   = ROWS * COLUMNS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int COLOR_W = ttw_pkg::COLOR_W;
   localparam logic [2:0] CSR_TEXT_COLOR = 3'd0;

   logic [COLOR_W-1:0] color_ff, color_in;
   logic               csr_write;

   ttw_pkg::ctl_type           ctl;
   ttw_pkg::st_type            st;
   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_addr;
   logic [ttw_pkg::CELL_W-1:0] ram_wdata;
   logic [ttw_pkg::CELL_W-1:0] ram_rdata;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign color_in   = (csr_write && csr_paddr == CSR_TEXT_COLOR) ? csr_pwdata[COLOR_W-1:0]
                                                                  : color_ff;
   assign csr_prdata = (csr_paddr == CSR_TEXT_COLOR) ? 32'(color_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) color_ff <= ttw_pkg::COLOR_RESET;
      else color_ff <= color_in;
   end

   ttw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .ctl       (ctl)
   );

   ttw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_cmd),
      .req_char_code  (req_char_code),
      .req_cell_row   (req_cell_row),
      .req_cell_col   (req_cell_col),
      .text_color     (color_ff),
      .ctl            (ctl),
      .st             (st),
      .ram_we         (ram_we),
      .ram_addr       (ram_addr),
      .ram_wdata      (ram_wdata),
      .ram_rdata      (ram_rdata),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cell_value (rsp_cell_value),
      .rsp_scrolled   (rsp_scrolled)
   );

   ttw_ram #(
      .WIDTH (ttw_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule
